/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the pulse peak detector.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ppd_pkg.sv */
// Package of the pulse peak detector: field widths, filter coefficients,
// register indexes and reset values. No dependencies.
package ppd_pkg;

    // Default datapath sizes
    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int LVL_W      = 12;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 32;
    localparam int WAVE_W     = 21;
    localparam int WAVE_FRAC  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Filter coefficients, 16 fraction bits
    localparam int COEF_W = 16;
    localparam logic [COEF_W-1:0] K_FAST_OLD = 16'd52429;
    localparam logic [COEF_W-1:0] K_FAST_NEW = 16'd13107;
    localparam logic [COEF_W-1:0] K_SLOW_OLD = 16'd65274;
    localparam logic [COEF_W-1:0] K_SLOW_NEW = 16'd262;
    localparam logic [COEF_W-1:0] K_DECAY    = 16'd65208;
    localparam logic [COEF_W-1:0] K_THRESH   = 16'd22938;
    localparam logic [COEF_W:0]   COEF_HALF  = 17'd32768;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAW_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LED_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FLOOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_LVL  = 3'd5;

    // Register reset values
    localparam logic [LVL_W-1:0] RAW_HIGH_RST   = 12'd4050;
    localparam logic [LVL_W-1:0] RAW_LOW_RST    = 12'd50;
    localparam logic [MS_W-1:0]  REFRACTORY_RST = 16'd400;
    localparam logic [MS_W-1:0]  LED_HOLD_RST   = 16'd90;
    localparam logic [LVL_W-1:0] THR_FLOOR_RST  = 12'd40;
    localparam logic [LVL_W-1:0] START_LVL_RST  = 12'd2000;

endpackage

/* rtl/pulse_peak_detector_core.sv */
// Pulse peak detector top level: sequencer around one shared multiplier.
// Depends on ppd_pkg and assert_macros.svh.
//
// A present sample, once accepted, runs through ten sequencer steps before the
// next is taken: they run the fast average, slow average, peak decay and
// threshold products one after another through the single 28x16 multiplier,
// each product registered before it is summed or compared. A sample outside
// the limits goes straight to the last step. The result beat sits in an output
// register; the block holds in its last step while a previous result has not
// been taken. Writing start_level reloads both averages at once.
`include "assert_macros.svh"

module pulse_peak_detector_core #(
    parameter int SAMPLE_BITS   = ppd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = ppd_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [SAMPLE_BITS-1:0]                raw_sample,
    input  logic [ppd_pkg::TIME_W-1:0]            time_ms,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  sensor_present,
    output logic                                  beat_detected,
    output logic                                  led_lit,
    output logic signed [ppd_pkg::WAVE_W-1:0]     wave_offset,
    input  logic                                  cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ppd_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int AVG_W   = SAMPLE_BITS + FRACTION_BITS;
    localparam int COEF_W  = ppd_pkg::COEF_W;
    localparam int PROD_W  = AVG_W + COEF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int WAVE_IW = AVG_W + 1;
    localparam int LVL_W   = ppd_pkg::LVL_W;
    localparam int MS_W    = ppd_pkg::MS_W;
    localparam int TIME_W  = ppd_pkg::TIME_W;
    localparam int WAVE_W  = ppd_pkg::WAVE_W;
    localparam int FLR_W   = LVL_W + FRACTION_BITS;
    localparam int THR_W   = (AVG_W > FLR_W) ? AVG_W : FLR_W;
    localparam int CMP_W   = ((THR_W > WAVE_IW) ? THR_W : WAVE_IW) + 2;
    localparam int WSHIFT  = FRACTION_BITS - ppd_pkg::WAVE_FRAC;
    localparam int WIDE_W  = WAVE_IW + WAVE_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAST_OLD,
        ST_FAST_NEW,
        ST_FAST_SUM,
        ST_SLOW_OLD,
        ST_SLOW_NEW,
        ST_SLOW_SUM,
        ST_WAVE,
        ST_PEAK,
        ST_THRESH,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [LVL_W-1:0] raw_high_reg;
    logic [LVL_W-1:0] raw_low_reg;
    logic [MS_W-1:0]  refractory_reg;
    logic [MS_W-1:0]  led_hold_reg;
    logic [LVL_W-1:0] thr_floor_reg;

    // Detector state
    logic [AVG_W-1:0]  fast_reg;
    logic [AVG_W-1:0]  slow_reg;
    logic [AVG_W-1:0]  peak_reg;
    logic              armed_reg;
    logic              led_reg;
    logic [TIME_W-1:0] led_stamp_reg;
    logic [TIME_W-1:0] beat_stamp_reg;
    logic              absent_reg;

    // Working registers
    logic [SAMPLE_BITS-1:0]    raw_reg;
    logic [TIME_W-1:0]         time_reg;
    logic [TIME_W-1:0]         beat_gap_reg;
    logic [TIME_W-1:0]         led_gap_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         acc_reg;
    logic signed [WAVE_IW-1:0] wave_reg;

    // Output registers
    logic                     out_valid_reg;
    logic                     present_reg;
    logic                     beat_reg;
    logic                     led_out_reg;
    logic signed [WAVE_W-1:0] wave_out_reg;

    // Combinational datapath
    logic [AVG_W-1:0]          mul_a;
    logic [COEF_W-1:0]         mul_b;
    logic                      mul_load;
    logic [PROD_W-1:0]         prod;
    logic [SUM_W-1:0]          rnd_sum;
    logic [AVG_W-1:0]          avg_rnd;
    logic [AVG_W-1:0]          prod_hi;
    logic signed [WAVE_IW-1:0] wave_diff;
    logic                      wave_pos;
    logic                      wave_over_peak;
    logic [THR_W-1:0]          thr_mul;
    logic [THR_W-1:0]          thr_flr;
    logic [THR_W-1:0]          thr;
    logic signed [CMP_W-1:0]   wave_c;
    logic signed [CMP_W-1:0]   wave2_c;
    logic signed [CMP_W-1:0]   thr_c;
    logic                      beat_fire;
    logic                      armed_after;
    logic                      armed_new;
    logic                      led_new;
    logic signed [WAVE_IW-1:0] wave_sh;
    logic signed [WIDE_W-1:0]  wave_wide;
    logic                      absent_in;
    logic                      slot_free;
    logic [AVG_W-1:0]          start_avg;

    // Terms of the consistency checks
    logic                      chk_out_beat;
    logic                      chk_beat_ok;
    logic                      chk_out_absent;
    logic                      chk_absent_ok;
    logic                      chk_in_take;
    logic                      chk_sum_step;

    assign in_ready  = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;
    assign absent_in = (raw_sample >= raw_high_reg) || (raw_sample <= raw_low_reg);
    assign start_avg = AVG_W'({cfg_data[LVL_W-1:0], {FRACTION_BITS{1'b0}}});

    // Select multiplier operands for each step
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        mul_load = 1'b1;
        unique case (state_reg)
            ST_FAST_OLD:
            begin
                mul_a = fast_reg;
                mul_b = ppd_pkg::K_FAST_OLD;
            end
            ST_FAST_NEW:
            begin
                mul_a = {raw_reg, {FRACTION_BITS{1'b0}}};
                mul_b = ppd_pkg::K_FAST_NEW;
            end
            ST_SLOW_OLD:
            begin
                mul_a = slow_reg;
                mul_b = ppd_pkg::K_SLOW_OLD;
            end
            ST_SLOW_NEW:
            begin
                mul_a = fast_reg;
                mul_b = ppd_pkg::K_SLOW_NEW;
            end
            ST_WAVE:
            begin
                mul_a = peak_reg;
                mul_b = ppd_pkg::K_DECAY;
            end
            ST_THRESH:
            begin
                mul_a = peak_reg;
                mul_b = ppd_pkg::K_THRESH;
            end
            default:
            begin
                mul_load = 1'b0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Round the two-term average and drop the coefficient fraction
    assign rnd_sum = SUM_W'(acc_reg) + SUM_W'(prod_reg) + SUM_W'(ppd_pkg::COEF_HALF);
    assign avg_rnd = rnd_sum[COEF_W +: AVG_W];
    assign prod_hi = prod_reg[COEF_W +: AVG_W];

    assign wave_diff = $signed(WAVE_IW'(fast_reg)) - $signed(WAVE_IW'(slow_reg));

    // Peak tracking: raise the decayed peak to a larger positive wave
    assign wave_pos       = !wave_reg[WAVE_IW-1] && (wave_reg != '0);
    assign wave_over_peak = wave_pos && (WAVE_IW'(wave_reg) > WAVE_IW'(prod_hi));

    // Threshold is the larger of the floor and 0.35 times the peak
    assign thr_mul = THR_W'(prod_hi);
    assign thr_flr = THR_W'({thr_floor_reg, {FRACTION_BITS{1'b0}}});
    assign thr     = (thr_mul < thr_flr) ? thr_flr : thr_mul;

    assign wave_c  = CMP_W'(wave_reg);
    assign wave2_c = wave_c <<< 1;
    assign thr_c   = $signed(CMP_W'(thr));

    // Beat, rearm and LED decisions
    assign beat_fire   = !armed_reg && (wave_c > thr_c)
                         && (beat_gap_reg > TIME_W'(refractory_reg));
    assign armed_after = armed_reg || beat_fire;
    assign armed_new   = armed_after && !(wave2_c < thr_c);
    assign led_new     = beat_fire || (led_reg && !(led_gap_reg > TIME_W'(led_hold_reg)));

    // Scale the wave to 8 fraction bits, rounding toward minus infinity
    assign wave_sh   = wave_reg >>> WSHIFT;
    assign wave_wide = WIDE_W'(wave_sh);

    // Sequencer, detector state, configuration and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            raw_high_reg   <= ppd_pkg::RAW_HIGH_RST;
            raw_low_reg    <= ppd_pkg::RAW_LOW_RST;
            refractory_reg <= ppd_pkg::REFRACTORY_RST;
            led_hold_reg   <= ppd_pkg::LED_HOLD_RST;
            thr_floor_reg  <= ppd_pkg::THR_FLOOR_RST;
            fast_reg       <= AVG_W'({ppd_pkg::START_LVL_RST, {FRACTION_BITS{1'b0}}});
            slow_reg       <= AVG_W'({ppd_pkg::START_LVL_RST, {FRACTION_BITS{1'b0}}});
            peak_reg       <= '0;
            armed_reg      <= 1'b0;
            led_reg        <= 1'b0;
            led_stamp_reg  <= '0;
            beat_stamp_reg <= '0;
            absent_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            present_reg    <= 1'b0;
            beat_reg       <= 1'b0;
            led_out_reg    <= 1'b0;
            wave_out_reg   <= '0;
        end
        else
        begin
            // Raise the result beat as the last step ends; drop it once taken
            if (state_reg == ST_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        absent_reg <= absent_in;
                        state_reg  <= absent_in ? ST_DONE : ST_FAST_OLD;
                    end
                end
                ST_FAST_OLD: state_reg <= ST_FAST_NEW;
                ST_FAST_NEW: state_reg <= ST_FAST_SUM;
                ST_FAST_SUM:
                begin
                    fast_reg  <= avg_rnd;
                    state_reg <= ST_SLOW_OLD;
                end
                ST_SLOW_OLD: state_reg <= ST_SLOW_NEW;
                ST_SLOW_NEW: state_reg <= ST_SLOW_SUM;
                ST_SLOW_SUM:
                begin
                    slow_reg  <= avg_rnd;
                    state_reg <= ST_WAVE;
                end
                ST_WAVE: state_reg <= ST_PEAK;
                ST_PEAK:
                begin
                    peak_reg  <= wave_over_peak ? wave_reg[AVG_W-1:0] : prod_hi;
                    state_reg <= ST_THRESH;
                end
                ST_THRESH: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    // Hold until the output register is free
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (absent_reg)
                        begin
                            armed_reg    <= 1'b0;
                            led_reg      <= 1'b0;
                            present_reg  <= 1'b0;
                            beat_reg     <= 1'b0;
                            led_out_reg  <= 1'b0;
                            wave_out_reg <= '0;
                        end
                        else
                        begin
                            armed_reg    <= armed_new;
                            led_reg      <= led_new;
                            present_reg  <= 1'b1;
                            beat_reg     <= beat_fire;
                            led_out_reg  <= led_new;
                            wave_out_reg <= wave_wide[WAVE_W-1:0];
                            if (beat_fire)
                            begin
                                led_stamp_reg  <= time_reg;
                                beat_stamp_reg <= time_reg;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // Configuration writes; start level also reloads the averages
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ppd_pkg::REG_RAW_HIGH:   raw_high_reg   <= cfg_data[LVL_W-1:0];
                    ppd_pkg::REG_RAW_LOW:    raw_low_reg    <= cfg_data[LVL_W-1:0];
                    ppd_pkg::REG_REFRACTORY: refractory_reg <= cfg_data[MS_W-1:0];
                    ppd_pkg::REG_LED_HOLD:   led_hold_reg   <= cfg_data[MS_W-1:0];
                    ppd_pkg::REG_THR_FLOOR:  thr_floor_reg  <= cfg_data[LVL_W-1:0];
                    ppd_pkg::REG_START_LVL:
                    begin
                        fast_reg <= start_avg;
                        slow_reg <= start_avg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Working registers of the sequencer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_reg  <= raw_sample;
            time_reg <= time_ms;
        end
        if (mul_load)
        begin
            prod_reg <= prod;
        end
        unique case (state_reg)
            ST_FAST_OLD:
            begin
                beat_gap_reg <= time_reg - beat_stamp_reg;
                led_gap_reg  <= time_reg - led_stamp_reg;
            end
            ST_FAST_NEW: acc_reg  <= prod_reg;
            ST_SLOW_NEW: acc_reg  <= prod_reg;
            ST_WAVE:     wave_reg <= wave_diff;
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign sensor_present = present_reg;
    assign beat_detected  = beat_reg;
    assign led_lit        = led_out_reg;
    assign wave_offset    = wave_out_reg;

    // Consistency checks
    assign chk_out_beat   = out_valid_reg && beat_reg;
    assign chk_beat_ok    = present_reg && led_out_reg;
    assign chk_out_absent = out_valid_reg && !present_reg;
    assign chk_absent_ok  = (wave_out_reg == '0) && !led_out_reg && !beat_reg;
    assign chk_in_take    = in_valid && in_ready;
    assign chk_sum_step   = (state_reg == ST_FAST_SUM) || (state_reg == ST_SLOW_SUM);

    `ASSERT_IMPLIES(a_beat_lights_led, chk_out_beat, chk_beat_ok, "beat without LED or sensor")
    `ASSERT_IMPLIES(a_absent_quiet, chk_out_absent, chk_absent_ok, "absent sample not zero")
    `ASSERT_NEXT(a_busy_after_accept, chk_in_take, !in_ready, "second sample taken early")
    `ASSERT_ALWAYS(a_absent_skips_math, !(absent_reg && chk_sum_step), "filters moved while absent")

endmodule

/* dv/ppd_result_check.sv */
`timescale 1ns / 100ps
// Result checker for the pulse peak detector: watches the sample, result and
// register write ports, predicts every result and compares it field by field.
// Depends on ppd_pkg.
module ppd_result_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [ppd_pkg::SAMPLE_BITS_DEF-1:0] raw_sample,
    input  logic [ppd_pkg::TIME_W-1:0]          time_ms,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                sensor_present,
    input  logic                                beat_detected,
    input  logic                                led_lit,
    input  logic signed [ppd_pkg::WAVE_W-1:0]   wave_offset,
    input  logic                                cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  mismatches,
    output int                                  results_owed
);
    import ppd_pkg::*;

    localparam int FRAC  = FRACTION_BITS_DEF;
    localparam int AVG_W = SAMPLE_BITS_DEF + FRACTION_BITS_DEF;

    typedef struct packed {
        logic                     present;
        logic                     beat;
        logic                     led;
        logic signed [WAVE_W-1:0] wave;
    } pulse_result_t;

    // Register copies
    logic [LVL_W-1:0] high_lim, low_lim, floor_lvl, start_lvl;
    logic [MS_W-1:0]  refractory, led_hold;

    // Detector state
    logic [AVG_W-1:0]  fast_avg, slow_avg, peak_lvl;
    logic              armed, led_on;
    logic [TIME_W-1:0] led_stamp, beat_stamp;

    pulse_result_t expected_q[$];
    pulse_result_t oldest;

    // Advance the detector by one sample and return the result it gives
    function automatic pulse_result_t next_result(input logic [SAMPLE_BITS_DEF-1:0] raw,
                                                  input logic [TIME_W-1:0] now);
        pulse_result_t res;
        logic [63:0]   acc;
        logic [63:0]   thr;
        longint        wave;
        res = '0;
        // Out-of-range sample: clear flags, hold the filters
        if (raw >= high_lim || raw <= low_lim)
        begin
            armed  = 1'b0;
            led_on = 1'b0;
            return res;
        end
        // Fast and slow averages, rounded half up
        acc = 64'(fast_avg) * K_FAST_OLD + (64'(raw) << FRAC) * K_FAST_NEW + COEF_HALF;
        fast_avg = AVG_W'(acc >> COEF_W);
        acc = 64'(slow_avg) * K_SLOW_OLD + 64'(fast_avg) * K_SLOW_NEW + COEF_HALF;
        slow_avg = AVG_W'(acc >> COEF_W);
        wave = longint'(64'(fast_avg)) - longint'(64'(slow_avg));
        // Decay the peak, then raise it to the wave
        peak_lvl = AVG_W'((64'(peak_lvl) * K_DECAY) >> COEF_W);
        if (wave > 0 && wave > longint'(64'(peak_lvl)))
            peak_lvl = AVG_W'(wave);
        // Threshold is the larger of the floor and a fraction of the peak
        thr = (64'(peak_lvl) * K_THRESH) >> COEF_W;
        if (thr < (64'(floor_lvl) << FRAC))
            thr = 64'(floor_lvl) << FRAC;
        // Fire a beat on a crossing while disarmed and past the refractory time
        if (!armed && wave > longint'(thr)
            && TIME_W'(now - beat_stamp) > TIME_W'(refractory))
        begin
            led_on     = 1'b1;
            led_stamp  = now;
            beat_stamp = now;
            armed      = 1'b1;
            res.beat   = 1'b1;
        end
        // Rearm below half the threshold
        if (armed && 2 * wave < longint'(thr))
            armed = 1'b0;
        // Drop the LED after its hold time
        if (led_on && TIME_W'(now - led_stamp) > TIME_W'(led_hold))
            led_on = 1'b0;
        res.present = 1'b1;
        res.led     = led_on;
        res.wave    = WAVE_W'(wave >>> (FRAC - WAVE_FRAC));
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ppd_result_check: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_lim     = RAW_HIGH_RST;
            low_lim      = RAW_LOW_RST;
            refractory   = REFRACTORY_RST;
            led_hold     = LED_HOLD_RST;
            floor_lvl    = THR_FLOOR_RST;
            start_lvl    = START_LVL_RST;
            fast_avg     = AVG_W'(start_lvl) << FRAC;
            slow_avg     = fast_avg;
            peak_lvl     = '0;
            armed        = 1'b0;
            led_on       = 1'b0;
            led_stamp    = '0;
            beat_stamp   = '0;
            mismatches   = 0;
            results_owed = 0;
            expected_q.delete();
        end
        else
        begin
            // Track register writes; a new start level reloads both averages
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RAW_HIGH:   high_lim   = cfg_data[LVL_W-1:0];
                    REG_RAW_LOW:    low_lim    = cfg_data[LVL_W-1:0];
                    REG_REFRACTORY: refractory = cfg_data[MS_W-1:0];
                    REG_LED_HOLD:   led_hold   = cfg_data[MS_W-1:0];
                    REG_THR_FLOOR:  floor_lvl  = cfg_data[LVL_W-1:0];
                    REG_START_LVL:
                    begin
                        start_lvl = cfg_data[LVL_W-1:0];
                        fast_avg  = AVG_W'(start_lvl) << FRAC;
                        slow_avg  = fast_avg;
                    end
                    default: ;
                endcase
            end

            // Predict on every accepted sample
            if (in_valid && in_ready)
                expected_q.push_back(next_result(raw_sample, time_ms));

            // Compare every accepted result with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    if (sensor_present !== oldest.present)
                        report_mismatch($sformatf("sensor_present got %b want %b",
                                                  sensor_present, oldest.present));
                    if (beat_detected !== oldest.beat)
                        report_mismatch($sformatf("beat_detected got %b want %b",
                                                  beat_detected, oldest.beat));
                    if (led_lit !== oldest.led)
                        report_mismatch($sformatf("led_lit got %b want %b",
                                                  led_lit, oldest.led));
                    if (wave_offset !== oldest.wave)
                        report_mismatch($sformatf("wave_offset got %0d want %0d",
                                                  wave_offset, oldest.wave));
                end
            end
            results_owed = expected_q.size();
        end
    end

endmodule

/* dv/tb_pulse_peak_detector_core.sv */
`timescale 1ns / 100ps
// Testbench top for pulse_peak_detector_core: drives samples, register writes
// and result back-pressure, and gives the verdict from ppd_result_check.
// Depends on ppd_pkg, ppd_result_check and the RTL.
module tb_pulse_peak_detector_core;
    import ppd_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 180;
    localparam int CALM_PHASE    = 4;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [SAMPLE_BITS_DEF-1:0]    raw_sample;
    logic [TIME_W-1:0]             time_ms;
    logic                          out_valid;
    logic                          out_ready;
    logic                          sensor_present;
    logic                          beat_detected;
    logic                          led_lit;
    logic signed [WAVE_W-1:0]      wave_offset;
    logic                          cfg_we;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    int                mismatches;
    int                results_owed;
    int                idle_cycles;
    int                items_sent;
    bit                calm;
    logic [LVL_W-1:0]  cur_high, cur_low;

    pulse_peak_detector_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_sample     (raw_sample),
        .time_ms        (time_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sensor_present (sensor_present),
        .beat_detected  (beat_detected),
        .led_lit        (led_lit),
        .wave_offset    (wave_offset),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    ppd_result_check result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_sample     (raw_sample),
        .time_ms        (time_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sensor_present (sensor_present),
        .beat_detected  (beat_detected),
        .led_lit        (led_lit),
        .wave_offset    (wave_offset),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random, except in the calm stretch
    always @(posedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 19);
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_pulse_peak_detector_core: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one sample beat, after an optional random gap, and wait for it
    task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] raw,
                               input logic [TIME_W-1:0] stamp);
        if (!calm && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        raw_sample <= raw;
        time_ms    <= stamp;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (results_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Program every register for one phase; junk in the unused upper bits
    task automatic load_phase_setting(input int phase);
        logic [LVL_W-1:0] hi, lo, flr, lvl;
        logic [MS_W-1:0]  refr, hold;
        hi   = LVL_W'($urandom_range(3300, 4095));
        lo   = LVL_W'($urandom_range(0, 700));
        refr = MS_W'($urandom_range(0, 800));
        hold = MS_W'($urandom_range(0, 300));
        flr  = LVL_W'($urandom_range(0, 200));
        lvl  = LVL_W'($urandom_range(0, 4095));
        case (phase)
            1:
            begin
                hi   = '1;
                lo   = '0;
                refr = '0;
                hold = '0;
                flr  = '0;
                lvl  = '0;
            end
            2:
            begin
                hi   = '1;
                lo   = '0;
                refr = '1;
                hold = '1;
                flr  = '1;
                lvl  = '1;
            end
            3:
            begin
                hi = '0;
                lo = '1;
            end
            5:
            begin
                hi = 12'd1500;
                lo = 12'd2500;
            end
            default: ;
        endcase
        write_reg(REG_RAW_HIGH,   {4'($urandom), hi});
        write_reg(REG_RAW_LOW,    {4'($urandom), lo});
        write_reg(REG_REFRACTORY, refr);
        write_reg(REG_LED_HOLD,   hold);
        write_reg(REG_THR_FLOOR,  {4'($urandom), flr});
        write_reg(REG_START_LVL,  {4'($urandom), lvl});
        write_reg(phase[0] ? REG_NONE_HI : REG_NONE_LO, CFG_DATA_W'($urandom));
        cfg_we   <= 1'b0;
        cur_high  = hi;
        cur_low   = lo;
    endtask

    initial
    begin
        int                phase;
        int                mode;
        int                base;
        int                amp;
        int                period;
        int                width;
        int                step;
        int                reps;
        int                lvl;
        int                n;
        logic [TIME_W-1:0] clock_ms;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        raw_sample <= '0;
        time_ms    <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_RAW_HIGH;
        cfg_data   <= '0;
        calm        = 1'b0;
        items_sent  = 0;
        cur_high    = RAW_HIGH_RST;
        cur_low     = RAW_LOW_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: limits, a beat and its LED hold, refractory, wrap, absence
        send_sample(12'd0, 32'd0);
        send_sample(12'd4095, 32'd1);
        send_sample(RAW_LOW_RST, 32'd2);
        send_sample(RAW_HIGH_RST, 32'd3);
        send_sample(RAW_LOW_RST + 12'd1, 32'd4);
        send_sample(RAW_HIGH_RST - 12'd1, 32'd5);
        send_sample(12'd2000, 32'd10);
        send_sample(12'd2000, 32'd20);
        send_sample(12'd2600, 32'd500);
        send_sample(12'd3200, 32'd520);
        send_sample(12'd3200, 32'd520);
        send_sample(12'd2000, 32'd560);
        send_sample(12'd2000, 32'd640);
        send_sample(12'd1900, 32'd700);
        send_sample(12'd3400, 32'd760);
        send_sample(12'd2000, 32'hFFFF_FF00);
        send_sample(12'd3600, 32'hFFFF_FFFF);
        send_sample(12'd2000, 32'h0000_0010);
        send_sample(12'd3600, 32'h0000_0200);
        send_sample(12'd0, 32'h0000_0210);
        send_sample(12'd3800, 32'h0000_0400);
        send_sample(12'hAAA, 32'h5555_5555);
        send_sample(12'h555, 32'hAAAA_AAAA);
        drain_results();

        // Random phases, each under its own register setting
        for (phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            load_phase_setting(phase);
            calm       = (phase == CALM_PHASE);
            items_sent = 0;
            if (phase % 2 == 0)
                clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 20000));
            else
                clock_ms = $urandom;
            while (items_sent < PHASE_ITEMS)
            begin
                mode = $urandom_range(0, 99);
                if (mode < 70)
                begin
                    // Pulse train: baseline with periodic bumps and small noise
                    base   = $urandom_range(300, 3800);
                    amp    = $urandom_range(30, 1500);
                    period = $urandom_range(6, 45);
                    width  = $urandom_range(1, 4);
                    step   = $urandom_range(0, 40);
                    reps   = $urandom_range(2, 4);
                    for (n = 0; n < reps * period; n++)
                    begin
                        lvl = base + int'($urandom_range(0, 16)) - 8;
                        if (n % period < width)
                            lvl += amp;
                        if (lvl > 4095)
                            lvl = 4095;
                        clock_ms += TIME_W'(step);
                        send_sample(SAMPLE_BITS_DEF'(lvl), clock_ms);
                    end
                end
                else if (mode < 85)
                begin
                    // Noise: any sample, any stamp
                    repeat ($urandom_range(1, 20))
                    begin
                        if ($urandom_range(0, 3) == 0)
                            clock_ms = $urandom;
                        else
                            clock_ms += TIME_W'($urandom_range(0, 2000));
                        send_sample(SAMPLE_BITS_DEF'($urandom), clock_ms);
                    end
                end
                else
                begin
                    // Probe drop-out: samples on and next to the limits
                    repeat ($urandom_range(1, 6))
                    begin
                        clock_ms += TIME_W'($urandom_range(0, 40));
                        case ($urandom_range(0, 5))
                            0: send_sample('0, clock_ms);
                            1: send_sample('1, clock_ms);
                            2: send_sample(cur_high, clock_ms);
                            3: send_sample(cur_low, clock_ms);
                            4: send_sample(cur_high - 12'd1, clock_ms);
                            default: send_sample(cur_low + 12'd1, clock_ms);
                        endcase
                    end
                end
            end
            drain_results();
        end

        calm = 1'b0;
        repeat (20) @(posedge clk);
        if (mismatches == 0 && results_owed == 0)
            $display("tb_pulse_peak_detector_core: done, clean");
        else
            $display("tb_pulse_peak_detector_core: done, errors");
        $finish;
    end

endmodule
